// ===== sv/assert_macros.svh =====
// Assertion macros shared by the RTL of the modular exponentiation block.
// No dependencies; the macros assume a clock aclk and an active-low reset aresetn.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check that an antecedent implies a consequent on the same edge.
`define MME_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("implication check failed");
// Check that an antecedent implies a consequent on the next edge.
`define MME_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define MME_ASSERT_IMPL(lbl, ante, cons)
`define MME_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== sv/mme_pkg.sv =====
// Package for the modular exponentiation block: widths, state codes, cell control.
// No dependencies.
package mme_pkg;
    localparam int WIDTH = 32;
    localparam int CNT_W = $clog2(WIDTH);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RED  = 3'd1;
    localparam logic [2:0] S_RFIN = 3'd2;
    localparam logic [2:0] S_CHK  = 3'd3;
    localparam logic [2:0] S_MUL  = 3'd4;
    localparam logic [2:0] S_UPD  = 3'd5;

    typedef struct packed {
        logic load;
        logic step;
    } mme_ctrl_t;
endpackage

// ===== sv/mme_cell.sv =====
// Interleaved modular multiply cell: one multiplier bit per cycle while step is set, MSB first.
// Depends on mme_pkg.
module mme_cell import mme_pkg::*; (
    input  logic             aclk,
    input  mme_ctrl_t        ctrl,
    input  logic [WIDTH-1:0] x_in,
    input  logic [WIDTH-1:0] y_in,
    input  logic [WIDTH:0]   n_in,
    output logic [WIDTH-1:0] r_out
);
    logic [WIDTH-1:0] r_reg, r_next;
    logic [WIDTH-1:0] x_reg, x_next;
    logic [WIDTH+1:0] t, n1, n2;

    always_comb begin
        n1 = {1'b0, n_in};
        n2 = {n_in, 1'b0};
        t  = {1'b0, r_reg, 1'b0} + (x_reg[WIDTH-1] ? {2'b00, y_in} : '0);
        if (t >= n2) begin
            t = t - n2;
        end else if (t >= n1) begin
            t = t - n1;
        end
        r_next = r_reg;
        x_next = x_reg;
        if (ctrl.load) begin
            r_next = '0;
            x_next = x_in;
        end else if (ctrl.step) begin
            r_next = t[WIDTH-1:0];
            x_next = {x_reg[WIDTH-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        r_reg <= r_next;
        x_reg <= x_next;
    end

    assign r_out = r_reg;
endmodule

// ===== sv/modular_exponentiation.sv =====
// Top level of the modular exponentiation block: sequencer, registers, two cells.
// Depends on mme_pkg, mme_cell and assert_macros.svh.
//
// Usage:
//   Write the modulus through cfg_wr_en/cfg_wr_data while the block is idle;
//   reset loads a modulus of 1, and a modulus of 0 acts as 2^32.
//   Each input transaction (s_valid/s_ready) carries a base and an exponent;
//   one output transaction (m_valid/m_ready) returns base^exponent mod modulus.
//   A zero exponent returns 1 unreduced.
// Sequence:
//   32 cell steps and an update reduce the base, then each exponent bit up to
//   the highest set one takes a load, 32 steps and an update, and a final
//   check hands the result over once the output register is free. s_ready
//   rises with m_valid, so the next input transaction can be taken as soon
//   as the result is offered. The bit-serial modular multiply in the cells
//   sets the pace; the multiply and the square run side by side in two cells.
// One item is worked on at a time; s_ready is high only while idle.
// Stall: the result sits in an output register. A new transaction may be taken
//   while it waits; if the next result is ready before the old one is taken,
//   hold the finished value until m_ready frees the register.
// Reset (aresetn, synchronous, active low) drops any item in flight.
`include "assert_macros.svh"
module modular_exponentiation import mme_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic [WIDTH-1:0] cfg_wr_data,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [WIDTH-1:0] s_base,
    input  logic [WIDTH-1:0] s_exponent,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [WIDTH-1:0] m_power_result
);
    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [WIDTH-1:0] mod_reg;
    logic [WIDTH-1:0] e_reg, e_next;
    logic [WIDTH-1:0] acc_reg, acc_next;
    logic [WIDTH-1:0] pw_reg, pw_next;
    logic [WIDTH-1:0] out_reg, out_next;
    logic             out_valid_reg, out_valid_next;
    logic [WIDTH:0]   n_full;
    mme_ctrl_t        ctrl_a, ctrl_b;
    logic [WIDTH-1:0] xa, xb, yb;
    logic [WIDTH-1:0] ra, rb;
    logic             accept, out_free;

    // zero modulus stands for 2^WIDTH
    assign n_full = (mod_reg == '0) ? {1'b1, {WIDTH{1'b0}}} : {1'b0, mod_reg};

    assign s_ready  = (state_reg == S_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !out_valid_reg || m_ready;

    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        e_next         = e_reg;
        acc_next       = acc_reg;
        pw_next        = pw_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !m_ready;
        ctrl_a         = '0;
        ctrl_b         = '0;
        xa             = acc_reg;
        xb             = pw_reg;
        yb             = pw_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    // load the base into cell B and multiply by one to reduce it
                    e_next      = s_exponent;
                    xb          = s_base;
                    ctrl_b.load = 1'b1;
                    cnt_next    = '0;
                    state_next  = S_RED;
                end
            end
            S_RED: begin
                yb          = {{(WIDTH-1){1'b0}}, 1'b1};
                ctrl_b.step = 1'b1;
                cnt_next    = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(WIDTH-1)) begin
                    state_next = S_RFIN;
                end
            end
            S_RFIN: begin
                pw_next    = rb;
                acc_next   = {{(WIDTH-1){1'b0}}, 1'b1};
                state_next = S_CHK;
            end
            S_CHK: begin
                if (e_reg == '0) begin
                    // done: hand over once the output register is free
                    if (out_free) begin
                        out_next       = acc_reg;
                        out_valid_next = 1'b1;
                        state_next     = S_IDLE;
                    end
                end else begin
                    ctrl_a.load = 1'b1;
                    ctrl_b.load = 1'b1;
                    cnt_next    = '0;
                    state_next  = S_MUL;
                end
            end
            S_MUL: begin
                // multiply and square side by side
                ctrl_a.step = 1'b1;
                ctrl_b.step = 1'b1;
                cnt_next    = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(WIDTH-1)) begin
                    state_next = S_UPD;
                end
            end
            S_UPD: begin
                if (e_reg[0]) begin
                    acc_next = ra;
                end
                pw_next    = rb;
                e_next     = {1'b0, e_reg[WIDTH-1:1]};
                state_next = S_CHK;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            mod_reg       <= {{(WIDTH-1){1'b0}}, 1'b1};
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en) begin
                mod_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        e_reg   <= e_next;
        acc_reg <= acc_next;
        pw_reg  <= pw_next;
        out_reg <= out_next;
    end

    mme_cell u_cell_a (
        .aclk  (aclk),
        .ctrl  (ctrl_a),
        .x_in  (xa),
        .y_in  (pw_reg),
        .n_in  (n_full),
        .r_out (ra)
    );

    mme_cell u_cell_b (
        .aclk  (aclk),
        .ctrl  (ctrl_b),
        .x_in  (xb),
        .y_in  (yb),
        .n_in  (n_full),
        .r_out (rb)
    );

    assign m_valid        = out_valid_reg;
    assign m_power_result = out_reg;

    `MME_ASSERT_NEXT(a_accept_reduce, accept, state_reg == S_RED)
    `MME_ASSERT_IMPL(a_cnt_idle, (state_reg != S_RED) && (state_reg != S_MUL), cnt_reg == '0)
    `MME_ASSERT_NEXT(a_finish, (state_reg == S_CHK) && (e_reg == '0) && out_free, m_valid && s_ready)
endmodule

// ===== tb/sv/modular_exponentiation_tb.sv =====
// Self-checking testbench for the modular exponentiation block.
// Depends on mme_pkg and the modular_exponentiation RTL; a scoreboard class
// predicts base^exponent mod modulus and checks each output transaction.
module modular_exponentiation_tb import mme_pkg::*;;

    localparam int RANDOM_ITEMS = 540;
    localparam int DRAIN_CYCLES = 1200;
    localparam longint CYCLE_LIMIT = 3000000;

    // Hold the current modulus, the expected powers and the failure count.
    class power_scoreboard;
        logic [WIDTH-1:0] modulus_q;
        logic [WIDTH-1:0] pending_powers[$];
        int errors;

        function new();
            modulus_q = 1;
            errors = 0;
        endfunction

        function void set_modulus(logic [WIDTH-1:0] value);
            modulus_q = value;
        endfunction

        // Predict the power for one accepted input transaction.
        function void note_input(logic [WIDTH-1:0] base, logic [WIDTH-1:0] exponent);
            logic [63:0] acc;
            logic [63:0] pw;
            logic [63:0] n;
            logic [WIDTH-1:0] e;
            acc = 1;
            n = 64'(modulus_q);
            pw = 64'(base);
            e = exponent;
            if (n != 0) pw = pw % n;
            while (e != 0) begin
                if (e[0]) acc = (n == 0) ? ((acc * pw) & 64'hFFFF_FFFF) : (acc * pw) % n;
                pw = (n == 0) ? ((pw * pw) & 64'hFFFF_FFFF) : (pw * pw) % n;
                e = e >> 1;
            end
            pending_powers.push_back(acc[WIDTH-1:0]);
        endfunction

        function void check_result(logic [WIDTH-1:0] actual);
            logic [WIDTH-1:0] expected;
            if (pending_powers.size() == 0) begin
                $display("%0t: unexpected power_result %h", $time, actual);
                errors++;
            end else begin
                expected = pending_powers.pop_front();
                if (expected !== actual) begin
                    $display("%0t: power_result mismatch expected %h actual %h",
                             $time, expected, actual);
                    errors++;
                end
            end
        endfunction
    endclass

    logic             aclk;
    logic             aresetn;
    logic             cfg_wr_en;
    logic [WIDTH-1:0] cfg_wr_data;
    logic             s_valid;
    logic             s_ready;
    logic [WIDTH-1:0] s_base;
    logic [WIDTH-1:0] s_exponent;
    logic             m_valid;
    logic             m_ready;
    logic [WIDTH-1:0] m_power_result;

    power_scoreboard power_sb;
    longint cycle_count;

    modular_exponentiation i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_base        (s_base),
        .s_exponent    (s_exponent),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_power_result(m_power_result)
    );

    // 4-unit clock period.
    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    // Watchdog: fail the run if the cycle limit is reached.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Check each output transaction at the rising edge.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) power_sb.check_result(m_power_result);
    end

    // Randomize m_ready: draw a random stall per result, with calm stretches.
    initial begin : result_sink
        int stall;
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            stall = ($urandom_range(0, 7) < 3) ? 0 : $urandom_range(0, 4);
            @(negedge aclk);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            // Hold ready until a transaction completes.
            do @(posedge aclk); while (!m_valid);
        end
    end

    // Write the modulus; only called when the block is idle.
    task automatic write_modulus(logic [WIDTH-1:0] value);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        power_sb.set_modulus(value);
    endtask

    // Send one input transaction after a random gap, then drop valid.
    task automatic send_item(logic [WIDTH-1:0] base, logic [WIDTH-1:0] exponent);
        int gap;
        gap = $urandom_range(0, 4);
        @(negedge aclk);
        repeat (gap) @(negedge aclk);
        s_valid <= 1'b1;
        s_base <= base;
        s_exponent <= exponent;
        do @(posedge aclk); while (!s_ready);
        power_sb.note_input(base, exponent);
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    // Wait for every expected result, then let the block settle.
    task automatic drain();
        while (power_sb.pending_powers.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    // Bias exponents toward short bit lengths to keep the run short.
    function automatic logic [WIDTH-1:0] pick_exponent();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 6) return $urandom_range(0, 255);
        if (sel < 8) return $urandom() >> $urandom_range(0, 31);
        return $urandom();
    endfunction

    function automatic logic [WIDTH-1:0] pick_modulus();
        case ($urandom_range(0, 5))
            0: return 32'hFFFF_FFFF;
            1: return 32'hFFFF_FFFB;
            2: return $urandom_range(2, 1000);
            3: return 1;
            default: return $urandom();
        endcase
    endfunction

    initial begin : stimulus
        logic [WIDTH-1:0] mods[6];
        power_sb = new();
        cycle_count = 0;
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        s_valid = 1'b0;
        s_base = '0;
        s_exponent = '0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: reset modulus of one, zero and nonzero exponent with modulus one.
        send_item(32'd5, 32'd0);
        send_item(32'd5, 32'd3);
        drain();
        // Directed: extremes of base and exponent under small, large and zero moduli.
        mods = '{32'd1, 32'd7, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFB, 32'd2};
        foreach (mods[m]) begin
            write_modulus(mods[m]);
            send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF);
            send_item(32'd0, 32'd0);
            send_item(32'd0, 32'd1);
            if (m < 3) send_item(32'h8000_0001, 32'h0000_0002);
            drain();
        end

        // Random phases with a fresh modulus each.
        for (int p = 0; p < 12; p++) begin
            write_modulus(pick_modulus());
            repeat (RANDOM_ITEMS / 12) begin
                send_item($urandom(), pick_exponent());
            end
            drain();
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (power_sb.errors == 0 && power_sb.pending_powers.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule

// ===== modular_exponentiation.f =====
+incdir+sv
sv/mme_pkg.sv
sv/mme_cell.sv
sv/modular_exponentiation.sv
tb/sv/modular_exponentiation_tb.sv
